// File: rtl/core/lpht_pkg.sv
`default_nettype none
package lpht_pkg;

	localparam logic [31:0] HASH_SEED  = 32'd3323198485;
	localparam logic [31:0] HASH_MUL   = 32'h5bd1e995;
	localparam int unsigned HASH_SHIFT = 15;

	localparam int unsigned IN_DATA_W  = 104;
	localparam int unsigned OUT_DATA_W = 40;

	typedef enum logic {
		CMD_INSERT = 1'b0,
		CMD_FIND   = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_FULL      = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		HS_IDLE,
		HS_ROUND,
		HS_MOD
	} hash_state_t;

	typedef enum logic [2:0] {
		TS_CLEAR,
		TS_IDLE,
		TS_HASH,
		TS_READ,
		TS_CHECK
	} tbl_state_t;

endpackage
`default_nettype wire

// File: rtl/core/linear_probe_hash_table.sv
// Open-addressing hash table with linear probing, keyed by strings of up to
// KEY_CHARS bytes.
// Input channel s_*: one request per handshake. s_tuser carries the command
// (insert or find); s_tdata carries key bytes, key length and entry value.
// Output channel m_*: exactly one result per request, status and found value.
// After reset the table runs a clearing pass over the slot memory and takes
// no request until it ends.
// Steps per request: accept, start of the hash unit, hash rounds over the
// key bytes on the shared 32x32 multiplier, modulo reduction (4 bits per
// cycle), then per probed slot a registered memory read and a compare,
// which also loads the result.
// s_tready is high only while no request is in progress; a finished result
// sits in the output register, so the next request is taken while it waits.
// If the receiver stalls with a result still held, the next request stops at
// its final probe until the output register frees up.
`default_nettype none
module linear_probe_hash_table #(
	parameter int unsigned CAPACITY  = 32,
	parameter int unsigned KEY_CHARS = 8
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   s_tvalid,
	output logic                                        s_tready,
	// key_bytes[63:0], key_len[67:64], entry_value[99:68], zero pad
	input  wire logic [lpht_pkg::IN_DATA_W-1:0]         s_tdata,
	// cmd[0]
	input  wire logic [0:0]                             s_tuser,
	output logic                                        m_tvalid,
	input  wire logic                                   m_tready,
	// status[1:0], found_value[33:2], zero pad
	output logic [lpht_pkg::OUT_DATA_W-1:0]             m_tdata
);

	localparam int unsigned IW = $clog2(CAPACITY);
	localparam int unsigned KB = 8 * KEY_CHARS;
	localparam int unsigned WW = KB + 37;
	localparam int unsigned VB = KB + 36;

	lpht_pkg::tbl_state_t state_q, state_d;

	logic [WW-1:0] mem [CAPACITY];
	logic [WW-1:0] rdata_q;
	logic          mem_we;
	logic [IW-1:0] mem_waddr;
	logic [WW-1:0] mem_wdata;

	logic [IW-1:0] clr_q;
	logic [IW-1:0] idx_q;
	logic [IW-1:0] n_q;

	lpht_pkg::cmd_t cmd_q;
	logic [63:0]   key_q;
	logic [3:0]    len_q;
	logic [31:0]   val_q;

	logic                   m_tvalid_q;
	lpht_pkg::status_t      status_q;
	logic signed [31:0]     found_q;

	logic          accept;
	logic          out_free;
	logic [3:0]    len_sat;
	logic [63:0]   key_m;
	logic          hash_start;
	logic          hash_done;
	logic [IW-1:0] hash_idx;
	logic          u_hash_idle_q;

	logic              rd_valid;
	logic              rd_match;
	logic              last_probe;
	logic              chk_done;
	logic              chk_write;
	lpht_pkg::status_t chk_status;
	logic [31:0]       chk_value;
	logic [IW-1:0]     idx_next;

	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;

	assign len_sat = (s_tdata[67:64] > 4'(KEY_CHARS)) ? 4'(KEY_CHARS) : s_tdata[67:64];

	always_comb begin
		for (int i = 0; i < 8; i++) begin
			key_m[8*i +: 8] = (4'(i) < len_sat) ? s_tdata[8*i +: 8] : 8'd0;
		end
	end

	lpht_hash #(
		.CAPACITY (CAPACITY)
	) u_hash (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (hash_start),
		.key    (key_q),
		.len    (len_q),
		.done   (hash_done),
		.idx    (hash_idx)
	);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rdata_q <= mem[idx_q];
	end

	assign rd_valid   = rdata_q[VB];
	assign rd_match   = rd_valid && (rdata_q[KB+35:KB+32] == len_q)
	                    && (rdata_q[KB+31:32] == key_q[KB-1:0]);
	assign last_probe = (n_q == IW'(CAPACITY - 1));
	assign idx_next   = (idx_q == IW'(CAPACITY - 1)) ? '0 : idx_q + IW'(1);

	always_comb begin
		chk_done   = 1'b0;
		chk_write  = 1'b0;
		chk_status = lpht_pkg::ST_NOT_FOUND;
		chk_value  = 32'd0;
		if (cmd_q == lpht_pkg::CMD_INSERT) begin
			priority if (!rd_valid) begin
				chk_done   = 1'b1;
				chk_write  = 1'b1;
				chk_status = lpht_pkg::ST_OK;
			end else if (last_probe) begin
				chk_done   = 1'b1;
				chk_status = lpht_pkg::ST_FULL;
			end else begin
				chk_done = 1'b0;
			end
		end else begin
			priority if (!rd_valid) begin
				chk_done = 1'b1;
			end else if (rd_match) begin
				chk_done   = 1'b1;
				chk_status = lpht_pkg::ST_OK;
				chk_value  = rdata_q[31:0];
			end else if (last_probe) begin
				chk_done = 1'b1;
			end else begin
				chk_done = 1'b0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			lpht_pkg::TS_CLEAR: begin
				if (clr_q == IW'(CAPACITY - 1)) begin
					state_d = lpht_pkg::TS_IDLE;
				end
			end
			lpht_pkg::TS_IDLE: begin
				if (accept) begin
					state_d = lpht_pkg::TS_HASH;
				end
			end
			lpht_pkg::TS_HASH: begin
				if (hash_done) begin
					state_d = lpht_pkg::TS_READ;
				end
			end
			lpht_pkg::TS_READ: begin
				state_d = lpht_pkg::TS_CHECK;
			end
			lpht_pkg::TS_CHECK: begin
				if (!chk_done) begin
					state_d = lpht_pkg::TS_READ;
				end else if (out_free) begin
					state_d = lpht_pkg::TS_IDLE;
				end
			end
			default: state_d = lpht_pkg::TS_IDLE;
		endcase
	end

	always_comb begin
		s_tready   = (state_q == lpht_pkg::TS_IDLE);
		hash_start = (state_q == lpht_pkg::TS_HASH) && !hash_done
		             && (u_hash_idle_q);
		mem_we     = 1'b0;
		mem_waddr  = idx_q;
		mem_wdata  = {1'b1, len_q, key_q[KB-1:0], val_q};
		unique case (state_q)
			lpht_pkg::TS_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = '0;
			end
			lpht_pkg::TS_CHECK: begin
				mem_we = chk_write && out_free;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= lpht_pkg::TS_CLEAR;
			clr_q         <= '0;
			m_tvalid_q    <= 1'b0;
			u_hash_idle_q <= 1'b1;
		end else begin
			state_q <= state_d;
			if (state_q == lpht_pkg::TS_CLEAR) begin
				clr_q <= clr_q + IW'(1);
			end
			if (accept) begin
				u_hash_idle_q <= 1'b1;
			end else if (hash_start) begin
				u_hash_idle_q <= 1'b0;
			end
			if (state_q == lpht_pkg::TS_CHECK && chk_done && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= lpht_pkg::cmd_t'(s_tuser[0]);
			key_q <= key_m;
			len_q <= len_sat;
			val_q <= s_tdata[99:68];
		end
		if (hash_done) begin
			idx_q <= hash_idx;
			n_q   <= '0;
		end else if (state_q == lpht_pkg::TS_CHECK && !chk_done) begin
			idx_q <= idx_next;
			n_q   <= n_q + IW'(1);
		end
		if (state_q == lpht_pkg::TS_CHECK && chk_done && out_free) begin
			status_q <= chk_status;
			found_q  <= chk_value;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {6'd0, found_q, status_q};

	a_result_from_check: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> $past(state_q) == lpht_pkg::TS_CHECK)
		else $error("result loaded outside probe check");

	a_write_empty_only: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == lpht_pkg::TS_CHECK && mem_we) |-> !rdata_q[VB])
		else $error("insert overwrites an occupied slot");

	a_hash_in_hash_state: assert property (@(posedge clk) disable iff (!arst_n)
		hash_done |-> state_q == lpht_pkg::TS_HASH)
		else $error("hash result outside hash phase");

	a_probe_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == lpht_pkg::TS_CHECK |-> n_q <= IW'(CAPACITY - 1))
		else $error("probe count beyond capacity");

	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid_q && !m_tready) |=> m_tvalid_q && $stable(status_q) && $stable(found_q))
		else $error("stalled result changed");

endmodule
`default_nettype wire

// File: rtl/core/lpht_hash.sv
`default_nettype none
module lpht_hash #(
	parameter int unsigned CAPACITY = 32
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [63:0]                 key,
	input  wire logic [3:0]                  len,
	output logic                             done,
	output logic [$clog2(CAPACITY)-1:0]      idx
);

	localparam int unsigned IW = $clog2(CAPACITY);
	localparam int unsigned RW = IW + 1;

	lpht_pkg::hash_state_t state_q, state_d;

	logic [63:0]   key_q;
	logic [3:0]    left_q;
	logic          first_q;
	logic [31:0]   prod_q;
	logic [31:0]   hsh_q;
	logic [RW-1:0] rem_q;
	logic [2:0]    mcnt_q;

	logic [31:0]   cur;
	logic [31:0]   mix;
	logic [31:0]   prod_d;
	logic [RW-1:0] rem_d;

	assign cur    = first_q ? lpht_pkg::HASH_SEED
	                        : (prod_q ^ (prod_q >> lpht_pkg::HASH_SHIFT));
	assign mix    = cur ^ {24'd0, key_q[7:0]};
	assign prod_d = mix * lpht_pkg::HASH_MUL;

	always_comb begin
		logic [RW-1:0] r;
		logic [RW-1:0] r2;
		r  = rem_q;
		r2 = '0;
		for (int i = 0; i < 4; i++) begin
			r2 = {r[RW-2:0], hsh_q[31-i]};
			if (r2 >= RW'(CAPACITY)) begin
				r2 = r2 - RW'(CAPACITY);
			end
			r = r2;
		end
		rem_d = r;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			lpht_pkg::HS_IDLE: begin
				if (start) begin
					state_d = lpht_pkg::HS_ROUND;
				end
			end
			lpht_pkg::HS_ROUND: begin
				if (left_q == 4'd0) begin
					state_d = lpht_pkg::HS_MOD;
				end
			end
			lpht_pkg::HS_MOD: begin
				if (mcnt_q == 3'd7) begin
					state_d = lpht_pkg::HS_IDLE;
				end
			end
			default: state_d = lpht_pkg::HS_IDLE;
		endcase
	end

	always_comb begin
		done = (state_q == lpht_pkg::HS_MOD) && (mcnt_q == 3'd7);
		idx  = rem_d[IW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lpht_pkg::HS_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			lpht_pkg::HS_IDLE: begin
				key_q   <= key;
				left_q  <= len;
				first_q <= 1'b1;
			end
			lpht_pkg::HS_ROUND: begin
				if (left_q == 4'd0) begin
					hsh_q  <= cur;
					rem_q  <= '0;
					mcnt_q <= 3'd0;
				end else begin
					prod_q  <= prod_d;
					key_q   <= key_q >> 8;
					left_q  <= left_q - 4'd1;
					first_q <= 1'b0;
				end
			end
			lpht_pkg::HS_MOD: begin
				hsh_q  <= hsh_q << 4;
				rem_q  <= rem_d;
				mcnt_q <= mcnt_q + 3'd1;
			end
			default: begin
				first_q <= 1'b1;
			end
		endcase
	end

endmodule
`default_nettype wire
